// ----- hw/rtl/vtg_pkg.sv -----
package vtg_pkg;

  localparam int IDX_W  = 10;
  localparam int POS_W  = 24;
  localparam int NRM_W  = 16;
  localparam int UV_W   = 16;
  localparam int SUM_W  = 40;
  localparam int OUT_W  = 16;
  // shared divider: |numerator| << 13 over |det|, or |rejection| << 14 over len
  localparam int DVD_W  = 55;
  localparam int DVS_W  = 35;
  // square root unit
  localparam int SQ_W   = 63;
  localparam int ROOT_W = 32;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOAD = 2'd0;
  localparam op_t OP_TRI  = 2'd1;
  localparam op_t OP_READ = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] nrm_z;
    logic signed [NRM_W-1:0] nrm_y;
    logic signed [NRM_W-1:0] nrm_x;
    logic signed [UV_W-1:0]  tex_v;
    logic signed [UV_W-1:0]  tex_u;
  } attr_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] tan_x;
    logic signed [SUM_W-1:0] tan_y;
    logic signed [SUM_W-1:0] tan_z;
    logic signed [SUM_W-1:0] bit_x;
    logic signed [SUM_W-1:0] bit_y;
    logic signed [SUM_W-1:0] bit_z;
  } sums_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sq_req_t;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

  // signed saturation of a magnitude quotient
  function automatic logic signed [SUM_W-1:0] sat_quot(input logic [DVD_W-1:0] q,
                                                       input logic neg);
    logic [DVD_W-1:0] lim;
    lim = {{(DVD_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    if (neg) begin
      lim = lim + 1'b1;
    end
    if (q > lim) begin
      return neg ? SUM_MIN : SUM_MAX;
    end
    return neg ? -q[SUM_W-1:0] : q[SUM_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/vtg_ram.sv -----
module vtg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/vtg_div.sv -----
module vtg_div (
  input  logic                     clk,
  input  logic                     rst,
  input  vtg_pkg::div_req_t        req,
  output logic                     done,
  output logic [vtg_pkg::DVD_W-1:0] quot
);
  import vtg_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] dq;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic [DVS_W:0]   sh;
  logic [DVS_W:0]   diff;
  logic             ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    sh   = {rem, dq[DVD_W-1]};
    diff = sh - {1'b0, dvs};
    ge   = sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        dq      <= req.dividend;
        dvs     <= req.divisor;
      end else if (running) begin
        rem <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
        dq  <= {dq[DVD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quot = dq;

endmodule

// ----- hw/rtl/vtg_sqrt.sv -----
module vtg_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  vtg_pkg::sq_req_t           req,
  output logic                       done,
  output logic [vtg_pkg::ROOT_W-1:0] root
);
  import vtg_pkg::*;

  localparam int STEPS = (SQ_W + 1) / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [SQ_W-1:0]  x;
  logic [SQ_W-1:0]  res;
  logic [SQ_W-1:0]  bt;
  logic [SQ_W-1:0]  trial;
  logic [CNT_W-1:0] cnt;
  logic             running;

  assign trial = res + bt;

  // digit-by-digit integer square root, two radicand bits per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= '0;
        x       <= req.radicand;
        res     <= '0;
        bt      <= {1'b1, {(SQ_W-1){1'b0}}};
      end else if (running) begin
        if (x >= trial) begin
          x   <= x - trial;
          res <= (res >> 1) + bt;
        end else begin
          res <= res >> 1;
        end
        bt  <= bt >> 2;
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign root = res[ROOT_W-1:0];

endmodule

// ----- hw/rtl/vertex_tangent_generator_top.sv -----
// Per-vertex tangent generator. Vertex attributes and the tangent/bitangent sums live in two
// synchronous RAMs of VERTEX_DEPTH entries; every word is read, updated and written back by a
// sequencer, one word at a time. A word is taken when start is high and busy is low. A
// triangle spends almost all of its time in six divisions of 55 quotient steps each on the
// shared serial divider; a zero UV determinant ends it once the determinant is formed. A
// tangent read runs a normalizing shift, a square root, three divisions and the handedness
// shift; a zero rejection skips the root and the divisions. Its result shows for one cycle
// with out_valid, in the cycle busy drops, and cannot be held off. After reset the block
// clears every entry of the sum RAM, busy high. Indices fold modulo VERTEX_DEPTH.
module vertex_tangent_generator_top #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op,
  input  logic [vtg_pkg::IDX_W-1:0]         vertex_index,
  input  logic [vtg_pkg::IDX_W-1:0]         corner_two,
  input  logic [vtg_pkg::IDX_W-1:0]         corner_three,
  input  logic signed [vtg_pkg::POS_W-1:0]  pos_x,
  input  logic signed [vtg_pkg::POS_W-1:0]  pos_y,
  input  logic signed [vtg_pkg::POS_W-1:0]  pos_z,
  input  logic signed [vtg_pkg::NRM_W-1:0]  norm_x,
  input  logic signed [vtg_pkg::NRM_W-1:0]  norm_y,
  input  logic signed [vtg_pkg::NRM_W-1:0]  norm_z,
  input  logic signed [vtg_pkg::UV_W-1:0]   tex_u,
  input  logic signed [vtg_pkg::UV_W-1:0]   tex_v,
  output logic                              out_valid,
  output logic [vtg_pkg::IDX_W-1:0]         out_index,
  output logic signed [vtg_pkg::OUT_W-1:0]  tan_out_x,
  output logic signed [vtg_pkg::OUT_W-1:0]  tan_out_y,
  output logic signed [vtg_pkg::OUT_W-1:0]  tan_out_z
);
  import vtg_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);
  localparam bit NEED_MOD = VERTEX_DEPTH < (1 << IDX_W);
  localparam logic [19:0] RECIP = 20'((1 << 20) / VERTEX_DEPTH);
  localparam int RMAG_W = 46;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_MOD1, S_MOD2, S_LOAD,
    T_RA, T_RB, T_RC, T_RD, T_DIFF, T_DET1, T_DET2, T_PROD, T_NUM,
    T_DGOT, T_DWT, T_DGOB, T_DWB, T_SRD, T_SWR,
    R_RD, R_CAP, R_DOT1, R_DOT2, R_REJ1, R_REJ2, R_NORM, R_SQ1, R_SQ2, R_SQW,
    R_DGO, R_DW, R_SHR, R_CR1, R_CR2, R_CR3
  } state_t;

  state_t state;

  // index folding: quotient estimate by reciprocal, then one correction
  function automatic logic [AW-1:0] fold(input logic [IDX_W-1:0] idx,
                                         input logic [IDX_W-1:0] qe);
    logic [27:0] ext;
    logic [27:0] r;
    ext = 28'(idx);
    r   = ext - 28'(qe) * 28'(VERTEX_DEPTH);
    if (r >= 28'(VERTEX_DEPTH)) begin
      r = r - 28'(VERTEX_DEPTH);
    end
    if (!NEED_MOD) begin
      r = ext;
    end
    return r[AW-1:0];
  endfunction

  op_t              op_r;
  logic [IDX_W-1:0] raw_a, raw_b, raw_c;
  logic [IDX_W-1:0] qa, qb, qc;
  logic [AW-1:0]    ad_a, ad_b, ad_c;
  logic [AW-1:0]    clr_addr;
  attr_t            ld_attr;

  // RAM ports
  logic          attr_we, sums_we;
  logic [AW-1:0] attr_waddr, attr_raddr, sums_waddr, sums_raddr;
  attr_t         attr_wdata, attr_rd;
  sums_t         sums_wdata, sums_rd, acc;

  // triangle datapath
  attr_t                   va, vb, vc;
  logic signed [16:0]      x1, y1, x2, y2;
  logic signed [24:0]      e1 [3];
  logic signed [24:0]      e2 [3];
  logic signed [33:0]      p1, p2;
  logic signed [34:0]      det_v;
  logic                    det_neg;
  logic [DVS_W-1:0]        det_mag;
  logic signed [41:0]      m1, m2, m3, m4;
  logic signed [42:0]      tn, bn;
  logic [42:0]             tn_mag, bn_mag;
  logic signed [SUM_W-1:0] tc [3];
  logic signed [SUM_W-1:0] bc [3];
  logic [1:0]              cidx, cnr;
  logic [AW-1:0]           cnr_addr;

  // readout datapath
  sums_t                   sm;
  logic signed [NRM_W-1:0] nv [3];
  logic signed [SUM_W-1:0] tv [3];
  logic signed [SUM_W-1:0] bv [3];
  logic signed [55:0]      pn [3];
  logic signed [57:0]      dsum;
  logic signed [43:0]      d;
  logic signed [59:0]      nd [3];
  logic signed [45:0]      rv [3];
  logic [RMAG_W-1:0]       rmag [3];
  logic [2:0]              rneg;
  logic                    rzero, r_all_zero, r_big, r_small;
  logic [59:0]             sqv [3];
  logic [ROOT_W-1:0]       len;
  logic [14:0]             qo [3];
  logic [1:0]              qi;
  logic [SUM_W-1:0]        tmag [3];
  logic [SUM_W-1:0]        bmag [3];
  logic [2:0]              tneg, bneg;
  logic                    t_big, b_big;
  logic signed [20:0]      ts [3];
  logic signed [20:0]      bs [3];
  logic signed [41:0]      cpa [3];
  logic signed [41:0]      cpb [3];
  logic signed [58:0]      cr [3];
  logic signed [60:0]      dps;
  logic                    dp_pos;
  logic signed [OUT_W-1:0] qv [3];
  logic signed [OUT_W-1:0] ov [3];

  // shared units
  div_req_t          div_req;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;
  sq_req_t           sq_req;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;

  vtg_ram #(.WIDTH($bits(attr_t)), .DEPTH(VERTEX_DEPTH)) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (attr_waddr),
    .wdata (attr_wdata),
    .raddr (attr_raddr),
    .rdata (attr_rd)
  );

  vtg_ram #(.WIDTH($bits(sums_t)), .DEPTH(VERTEX_DEPTH)) u_sums_ram (
    .clk   (clk),
    .we    (sums_we),
    .waddr (sums_waddr),
    .wdata (sums_wdata),
    .raddr (sums_raddr),
    .rdata (sums_rd)
  );

  vtg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_q)
  );

  vtg_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sq_req),
    .done (sq_done),
    .root (sq_root)
  );

  assign busy = state != S_IDLE;

  always_comb begin
    case (cnr)
      2'd0:    cnr_addr = ad_a;
      2'd1:    cnr_addr = ad_b;
      default: cnr_addr = ad_c;
    endcase
  end

  always_comb begin
    acc.tan_x = sat_add(sums_rd.tan_x, tc[0]);
    acc.tan_y = sat_add(sums_rd.tan_y, tc[1]);
    acc.tan_z = sat_add(sums_rd.tan_z, tc[2]);
    acc.bit_x = sat_add(sums_rd.bit_x, bc[0]);
    acc.bit_y = sat_add(sums_rd.bit_y, bc[1]);
    acc.bit_z = sat_add(sums_rd.bit_z, bc[2]);
  end

  always_comb begin
    attr_we    = 1'b0;
    attr_waddr = ad_a;
    attr_wdata = ld_attr;
    attr_raddr = ad_a;
    sums_we    = 1'b0;
    sums_waddr = ad_a;
    sums_wdata = '0;
    sums_raddr = ad_a;
    case (state)
      S_CLEAR: begin
        sums_we    = 1'b1;
        sums_waddr = clr_addr;
      end
      S_LOAD: begin
        attr_we = 1'b1;
        sums_we = 1'b1;
      end
      T_RB: attr_raddr = ad_b;
      T_RC: attr_raddr = ad_c;
      T_SRD: sums_raddr = cnr_addr;
      T_SWR: begin
        sums_we    = 1'b1;
        sums_waddr = cnr_addr;
        sums_wdata = acc;
      end
      default: ;
    endcase
  end

  always_comb begin
    tn_mag = tn[42] ? 43'(-tn) : 43'(tn);
    bn_mag = bn[42] ? 43'(-bn) : 43'(bn);
    div_req.start    = state inside {T_DGOT, T_DGOB, R_DGO};
    div_req.divisor  = det_mag;
    div_req.dividend = DVD_W'({tn_mag, 13'd0});
    case (state)
      T_DGOB: div_req.dividend = DVD_W'({bn_mag, 13'd0});
      R_DGO: begin
        div_req.dividend = DVD_W'({rmag[0][29:0], 14'd0});
        div_req.divisor  = DVS_W'(len);
      end
      default: ;
    endcase
    sq_req.start    = state == R_SQ2;
    sq_req.radicand = SQ_W'(sqv[0]) + SQ_W'(sqv[1]) + SQ_W'(sqv[2]);
  end

  always_comb begin
    nv[0] = va.nrm_x;
    nv[1] = va.nrm_y;
    nv[2] = va.nrm_z;
    tv[0] = sm.tan_x;
    tv[1] = sm.tan_y;
    tv[2] = sm.tan_z;
    bv[0] = sm.bit_x;
    bv[1] = sm.bit_y;
    bv[2] = sm.bit_z;
    det_v = 35'(p1) - 35'(p2);
    dsum  = 58'(pn[0]) + 58'(pn[1]) + 58'(pn[2]);
    for (int i = 0; i < 3; i++) begin
      rv[i] = 46'(tv[i]) - 46'(nd[i] >>> 14);
      ts[i] = tneg[i] ? -$signed({1'b0, tmag[i][19:0]}) : $signed({1'b0, tmag[i][19:0]});
      bs[i] = bneg[i] ? -$signed({1'b0, bmag[i][19:0]}) : $signed({1'b0, bmag[i][19:0]});
    end
    r_all_zero = (rmag[0] == '0) && (rmag[1] == '0) && (rmag[2] == '0);
    r_big      = |{rmag[0][RMAG_W-1:30], rmag[1][RMAG_W-1:30], rmag[2][RMAG_W-1:30]};
    r_small    = ~|{rmag[0][RMAG_W-1:29], rmag[1][RMAG_W-1:29], rmag[2][RMAG_W-1:29]};
    t_big      = |{tmag[0][SUM_W-1:20], tmag[1][SUM_W-1:20], tmag[2][SUM_W-1:20]};
    b_big      = |{bmag[0][SUM_W-1:20], bmag[1][SUM_W-1:20], bmag[2][SUM_W-1:20]};
    dps        = 61'(cr[0]) + 61'(cr[1]) + 61'(cr[2]);
    dp_pos     = dps > 0;
    for (int i = 0; i < 3; i++) begin
      qv[i] = rzero ? '0 : $signed({1'b0, qo[i]});
      ov[i] = (rneg[i] ^ !dp_pos) ? -qv[i] : qv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(VERTEX_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_r          <= op;
            raw_a         <= vertex_index;
            raw_b         <= corner_two;
            raw_c         <= corner_three;
            ld_attr.pos_x <= pos_x;
            ld_attr.pos_y <= pos_y;
            ld_attr.pos_z <= pos_z;
            ld_attr.nrm_x <= norm_x;
            ld_attr.nrm_y <= norm_y;
            ld_attr.nrm_z <= norm_z;
            ld_attr.tex_u <= tex_u;
            ld_attr.tex_v <= tex_v;
            state         <= S_MOD1;
          end
        end
        S_MOD1: begin
          qa    <= IDX_W'((30'(raw_a) * 30'(RECIP)) >> 20);
          qb    <= IDX_W'((30'(raw_b) * 30'(RECIP)) >> 20);
          qc    <= IDX_W'((30'(raw_c) * 30'(RECIP)) >> 20);
          state <= S_MOD2;
        end
        S_MOD2: begin
          ad_a <= fold(raw_a, qa);
          ad_b <= fold(raw_b, qb);
          ad_c <= fold(raw_c, qc);
          case (op_r)
            OP_LOAD: state <= S_LOAD;
            OP_TRI:  state <= T_RA;
            OP_READ: state <= R_RD;
            default: state <= S_IDLE;
          endcase
        end
        S_LOAD: state <= S_IDLE;

        // triangle: fetch three corners
        T_RA: state <= T_RB;
        T_RB: begin
          va    <= attr_rd;
          state <= T_RC;
        end
        T_RC: begin
          vb    <= attr_rd;
          state <= T_RD;
        end
        T_RD: begin
          vc    <= attr_rd;
          state <= T_DIFF;
        end
        T_DIFF: begin
          x1    <= 17'(vb.tex_u) - 17'(va.tex_u);
          y1    <= 17'(vb.tex_v) - 17'(va.tex_v);
          x2    <= 17'(vc.tex_u) - 17'(va.tex_u);
          y2    <= 17'(vc.tex_v) - 17'(va.tex_v);
          e1[0] <= 25'(vb.pos_x) - 25'(va.pos_x);
          e1[1] <= 25'(vb.pos_y) - 25'(va.pos_y);
          e1[2] <= 25'(vb.pos_z) - 25'(va.pos_z);
          e2[0] <= 25'(vc.pos_x) - 25'(va.pos_x);
          e2[1] <= 25'(vc.pos_y) - 25'(va.pos_y);
          e2[2] <= 25'(vc.pos_z) - 25'(va.pos_z);
          state <= T_DET1;
        end
        T_DET1: begin
          p1    <= x1 * y2;
          p2    <= x2 * y1;
          cidx  <= '0;
          state <= T_DET2;
        end
        T_DET2: begin
          det_neg <= det_v[34];
          det_mag <= det_v[34] ? DVS_W'(-det_v) : DVS_W'(det_v);
          state   <= (det_v == '0) ? S_IDLE : T_PROD;
        end
        T_PROD: begin
          // component 0 is always at the head; rotate for the next one
          m1    <= e1[0] * y2;
          m2    <= e2[0] * y1;
          m3    <= e2[0] * x1;
          m4    <= e1[0] * x2;
          e1[0] <= e1[1];
          e1[1] <= e1[2];
          e1[2] <= e1[0];
          e2[0] <= e2[1];
          e2[1] <= e2[2];
          e2[2] <= e2[0];
          state <= T_NUM;
        end
        T_NUM: begin
          tn    <= 43'(m1) - 43'(m2);
          bn    <= 43'(m3) - 43'(m4);
          state <= T_DGOT;
        end
        T_DGOT: state <= T_DWT;
        T_DWT: begin
          if (div_done) begin
            tc[2] <= sat_quot(div_q, tn[42] ^ det_neg);
            tc[1] <= tc[2];
            tc[0] <= tc[1];
            state <= T_DGOB;
          end
        end
        T_DGOB: state <= T_DWB;
        T_DWB: begin
          if (div_done) begin
            bc[2] <= sat_quot(div_q, bn[42] ^ det_neg);
            bc[1] <= bc[2];
            bc[0] <= bc[1];
            if (cidx == 2'd2) begin
              cnr   <= '0;
              state <= T_SRD;
            end else begin
              cidx  <= cidx + 1'b1;
              state <= T_PROD;
            end
          end
        end
        // corners updated one after another, so repeated corners accumulate
        T_SRD: state <= T_SWR;
        T_SWR: begin
          if (cnr == 2'd2) begin
            state <= S_IDLE;
          end else begin
            cnr   <= cnr + 1'b1;
            state <= T_SRD;
          end
        end

        // readout
        R_RD: state <= R_CAP;
        R_CAP: begin
          va    <= attr_rd;
          sm    <= sums_rd;
          state <= R_DOT1;
        end
        R_DOT1: begin
          for (int i = 0; i < 3; i++) begin
            pn[i] <= nv[i] * tv[i];
          end
          state <= R_DOT2;
        end
        R_DOT2: begin
          d     <= 44'(dsum >>> 14);
          state <= R_REJ1;
        end
        R_REJ1: begin
          for (int i = 0; i < 3; i++) begin
            nd[i] <= nv[i] * d;
          end
          state <= R_REJ2;
        end
        R_REJ2: begin
          for (int i = 0; i < 3; i++) begin
            rneg[i] <= rv[i][45];
            rmag[i] <= rv[i][45] ? RMAG_W'(-rv[i]) : RMAG_W'(rv[i]);
            tneg[i] <= tv[i][SUM_W-1];
            tmag[i] <= tv[i][SUM_W-1] ? SUM_W'(-tv[i]) : SUM_W'(tv[i]);
            bneg[i] <= bv[i][SUM_W-1];
            bmag[i] <= bv[i][SUM_W-1] ? SUM_W'(-bv[i]) : SUM_W'(bv[i]);
          end
          rzero <= 1'b0;
          state <= R_NORM;
        end
        R_NORM: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (r_all_zero) begin
            rzero <= 1'b1;
            state <= R_SHR;
          end else if (r_big) begin
            for (int i = 0; i < 3; i++) begin
              rmag[i] <= rmag[i] >> 1;
            end
          end else if (r_small) begin
            for (int i = 0; i < 3; i++) begin
              rmag[i] <= rmag[i] << 1;
            end
          end else begin
            state <= R_SQ1;
          end
        end
        R_SQ1: begin
          for (int i = 0; i < 3; i++) begin
            sqv[i] <= rmag[i][29:0] * rmag[i][29:0];
          end
          state <= R_SQ2;
        end
        R_SQ2: state <= R_SQW;
        R_SQW: begin
          if (sq_done) begin
            len   <= sq_root;
            qi    <= '0;
            state <= R_DGO;
          end
        end
        R_DGO: state <= R_DW;
        R_DW: begin
          if (div_done) begin
            qo[2]   <= div_q[14:0];
            qo[1]   <= qo[2];
            qo[0]   <= qo[1];
            rmag[0] <= rmag[1];
            rmag[1] <= rmag[2];
            rmag[2] <= rmag[0];
            if (qi == 2'd2) begin
              state <= R_SHR;
            end else begin
              qi    <= qi + 1'b1;
              state <= R_DGO;
            end
          end
        end
        R_SHR: begin
          // handedness operands scaled below 2^20
          if (t_big) begin
            for (int i = 0; i < 3; i++) begin
              tmag[i] <= tmag[i] >> 1;
            end
          end
          if (b_big) begin
            for (int i = 0; i < 3; i++) begin
              bmag[i] <= bmag[i] >> 1;
            end
          end
          if (!t_big && !b_big) begin
            state <= R_CR1;
          end
        end
        R_CR1: begin
          cpa[0] <= ts[1] * bs[2];
          cpb[0] <= ts[2] * bs[1];
          cpa[1] <= ts[2] * bs[0];
          cpb[1] <= ts[0] * bs[2];
          cpa[2] <= ts[0] * bs[1];
          cpb[2] <= ts[1] * bs[0];
          state  <= R_CR2;
        end
        R_CR2: begin
          for (int i = 0; i < 3; i++) begin
            cr[i] <= (43'(cpa[i]) - 43'(cpb[i])) * nv[i];
          end
          state <= R_CR3;
        end
        R_CR3: begin
          out_valid <= 1'b1;
          out_index <= raw_a;
          tan_out_x <= ov[0];
          tan_out_y <= ov[1];
          tan_out_z <= ov[2];
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/vertex_tangent_generator_top_tb.sv -----
module vertex_tangent_generator_top_tb;
  import vtg_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint S_MAX = 64'sd549755813887;
  localparam longint S_MIN = -64'sd549755813888;
  localparam op_t OP_SKIP = 2'd3;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic signed [OUT_W-1:0] tx;
    logic signed [OUT_W-1:0] ty;
    logic signed [OUT_W-1:0] tz;
  } tangent_t;

  class tangent_scoreboard;
    tangent_t pending[$];
    int errors;
    int matched;

    function void note(tangent_t t);
      pending = {pending, t};
    endfunction

    function void check(tangent_t got);
      tangent_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected tangent word idx=%0d", $time, got.idx);
        errors++;
        return;
      end
      exp = pending.pop_front();
      matched++;
      if (exp.idx !== got.idx) begin
        $display("%0t: out_index expected %0d actual %0d", $time, exp.idx, got.idx);
        errors++;
      end
      if (exp.tx !== got.tx) begin
        $display("%0t: tan_out_x expected %0d actual %0d", $time, exp.tx, got.tx);
        errors++;
      end
      if (exp.ty !== got.ty) begin
        $display("%0t: tan_out_y expected %0d actual %0d", $time, exp.ty, got.ty);
        errors++;
      end
      if (exp.tz !== got.tz) begin
        $display("%0t: tan_out_z expected %0d actual %0d", $time, exp.tz, got.tz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] op = OP_LOAD;
  logic [IDX_W-1:0] vertex_index = '0, corner_two = '0, corner_three = '0;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [NRM_W-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
  logic signed [UV_W-1:0] tex_u = '0, tex_v = '0;
  logic out_valid;
  logic [IDX_W-1:0] out_index;
  logic signed [OUT_W-1:0] tan_out_x, tan_out_y, tan_out_z;

  always #6 clk = ~clk;

  vertex_tangent_generator_top #(.VERTEX_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .vertex_index(vertex_index), .corner_two(corner_two), .corner_three(corner_three),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .tex_u(tex_u), .tex_v(tex_v),
    .out_valid(out_valid), .out_index(out_index),
    .tan_out_x(tan_out_x), .tan_out_y(tan_out_y), .tan_out_z(tan_out_z)
  );

  // mirror of the vertex and sum memories
  longint m_pos[DEPTH][3];
  longint m_nrm[DEPTH][3];
  longint m_uv[DEPTH][2];
  longint m_tan[DEPTH][3];
  longint m_bit[DEPTH][3];
  bit loaded[DEPTH];

  tangent_scoreboard sb = new();
  int idle_pct = 0;
  int sent = 0, loads = 0, tris = 0, reads = 0, zero_det = 0;
  int quiet = 0;

  function automatic longint clamp40(longint x);
    if (x > S_MAX) return S_MAX;
    if (x < S_MIN) return S_MIN;
    return x;
  endfunction

  function automatic longint fshift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint isqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void shrink20(inout longint v[3]);
    longint unsigned mg[3];
    longint unsigned m;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = v[i] < 0 ? -v[i] : v[i];
      if (mg[i] > m) m = mg[i];
    end
    while (m >= (64'd1 << 20)) begin
      for (int i = 0; i < 3; i++) mg[i] >>= 1;
      m >>= 1;
    end
    for (int i = 0; i < 3; i++) v[i] = v[i] < 0 ? -longint'(mg[i]) : longint'(mg[i]);
  endfunction

  task automatic apply_triangle(int a, int b, int c);
    longint x1, y1, x2, y2, det, e1, e2, tn, bn;
    longint tc[3], bc[3];
    int cs[3];
    x1 = m_uv[b][0] - m_uv[a][0];
    y1 = m_uv[b][1] - m_uv[a][1];
    x2 = m_uv[c][0] - m_uv[a][0];
    y2 = m_uv[c][1] - m_uv[a][1];
    det = x1 * y2 - x2 * y1;
    if (det == 0) begin
      zero_det++;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      e1 = m_pos[b][i] - m_pos[a][i];
      e2 = m_pos[c][i] - m_pos[a][i];
      tn = e1 * y2 - e2 * y1;
      bn = e2 * x1 - e1 * x2;
      tc[i] = clamp40((tn * 8192) / det);
      bc[i] = clamp40((bn * 8192) / det);
    end
    cs = '{a, b, c};
    // repeated corners take each add in turn
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) begin
        m_tan[cs[k]][i] = clamp40(m_tan[cs[k]][i] + tc[i]);
        m_bit[cs[k]][i] = clamp40(m_bit[cs[k]][i] + bc[i]);
      end
  endtask

  function automatic tangent_t tangent_of(int v, logic [IDX_W-1:0] raw);
    tangent_t res;
    longint n[3], t[3], bt[3], r[3], o[3];
    longint d, dp;
    longint unsigned mg[3], m, sq, len;
    d = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = m_nrm[v][i];
      t[i] = m_tan[v][i];
      bt[i] = m_bit[v][i];
      d += n[i] * t[i];
    end
    d = fshift(d, 14);
    m = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = t[i] - fshift(n[i] * d, 14);
      mg[i] = r[i] < 0 ? -r[i] : r[i];
      if (mg[i] > m) m = mg[i];
      o[i] = 0;
    end
    if (m != 0) begin
      while (m >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) mg[i] >>= 1;
        m >>= 1;
      end
      while (m < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) mg[i] <<= 1;
        m <<= 1;
      end
      sq = 0;
      for (int i = 0; i < 3; i++) sq += mg[i] * mg[i];
      len = isqrt(sq);
      for (int i = 0; i < 3; i++) begin
        o[i] = longint'((mg[i] * 16384) / len);
        if (r[i] < 0) o[i] = -o[i];
      end
    end
    shrink20(t);
    shrink20(bt);
    dp = (t[1] * bt[2] - t[2] * bt[1]) * n[0] + (t[2] * bt[0] - t[0] * bt[2]) * n[1]
       + (t[0] * bt[1] - t[1] * bt[0]) * n[2];
    if (!(dp > 0))
      for (int i = 0; i < 3; i++) o[i] = -o[i];
    res.idx = raw;
    res.tx = o[0][15:0];
    res.ty = o[1][15:0];
    res.tz = o[2][15:0];
    return res;
  endfunction

  // word taken at this edge: update mirror, queue expectation
  task automatic predict_word();
    int a, b, c;
    a = vertex_index % DEPTH;
    b = corner_two % DEPTH;
    c = corner_three % DEPTH;
    case (op)
      OP_LOAD: begin
        m_pos[a] = '{pos_x, pos_y, pos_z};
        m_nrm[a] = '{norm_x, norm_y, norm_z};
        m_uv[a] = '{tex_u, tex_v};
        m_tan[a] = '{0, 0, 0};
        m_bit[a] = '{0, 0, 0};
        loaded[a] = 1;
        loads++;
      end
      OP_TRI: begin
        apply_triangle(a, b, c);
        tris++;
      end
      OP_READ: begin
        sb.note(tangent_of(a, vertex_index));
        reads++;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        predict_word();
        quiet <= 0;
      end else if (out_valid) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (out_valid)
        sb.check('{out_index, tan_out_x, tan_out_y, tan_out_z});
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("vertex_tangent_generator_top_tb failed");
        $finish;
      end
    end
  end

  // start stays high from word to word unless the sender idles
  task automatic send(logic [1:0] o, int a, int b, int c, longint px, longint py, longint pz,
                      int nx, int ny, int nz, int u, int v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    op <= o;
    vertex_index <= a;
    corner_two <= b;
    corner_three <= c;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    norm_x <= nx; norm_y <= ny; norm_z <= nz;
    tex_u <= u; tex_v <= v;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic load_rand(int a);
    send(OP_LOAD, a, $urandom, $urandom, $signed($urandom_range(24'hFFFFFF)),
         $signed($urandom_range(24'hFFFFFF)), $signed($urandom_range(24'hFFFFFF)),
         $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
         $signed(16'($urandom)), $signed(16'($urandom)));
  endtask

  function automatic int pick_loaded(int lo, int hi);
    int k;
    do k = $urandom_range(hi, lo); while (!loaded[k]);
    return k;
  endfunction

  // small mesh: load vertices, add triangles among them, read them back, some ignored ops
  task automatic mesh_burst(int lo, int hi);
    int n;
    n = $urandom_range(6, 2);
    for (int i = 0; i < n; i++) load_rand($urandom_range(hi, lo));
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(9) == 0) begin
        send(OP_SKIP, $urandom, $urandom, $urandom, 0, 0, 0, 0, 0, 0, 0, 0);
      end else if ($urandom_range(2) == 0) begin
        send(OP_READ, pick_loaded(lo, hi) + ($urandom_range(1) ? 0 : 0), 0, 0,
             0, 0, 0, 0, 0, 0, 0, 0);
      end else begin
        send(OP_TRI, pick_loaded(lo, hi), pick_loaded(lo, hi), pick_loaded(lo, hi),
             0, 0, 0, 0, 0, 0, 0, 0);
      end
    end
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    int lo;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes, repeated corners, zero determinant, zero rejection, ignored op
    send(OP_LOAD, 0, 0, 0, 24'sh7FFFFF, -24'sh800000, 0, 16'sh4000, 0, 0, 16'sh7FFF,
         -16'sh8000);
    send(OP_LOAD, 1, 0, 0, -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 0, 16'sh4000, 0,
         -16'sh8000, 16'sh7FFF);
    send(OP_LOAD, 2, 0, 0, 0, 0, -24'sh800000, 0, 0, -16'sh8000, 0, 0);
    send(OP_LOAD, 1023, 0, 0, 100, 200, 300, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 5, 5);
    send(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_TRI, 0, 1, 2, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_TRI, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_TRI, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_TRI, 1023, 1023, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_SKIP, 1023, 1023, 1023, -1, -1, -1, -1, -1, -1, -1, -1);
    for (int i = 0; i < 3; i++) send(OP_READ, i, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_LOAD, 3, 0, 0, 1 << 16, 0, 0, 0, 0, 16'sh4000, 0, 0);
    send(OP_LOAD, 4, 0, 0, 0, 1 << 16, 0, 0, 0, 16'sh4000, 16'sh2000, 0);
    send(OP_LOAD, 5, 0, 0, 0, 0, 1 << 16, 0, 0, 16'sh4000, 0, 16'sh2000);
    send(OP_TRI, 3, 4, 5, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(OP_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();

    // random meshes in idle phases; pools kept small so triangles share corners
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 80 : (ph == 2) ? 29 : 0;
      while (sent < 357 * (ph + 1)) begin
        lo = $urandom_range(1023 - 15);
        if ($urandom_range(3) == 0) lo = $urandom_range(1) ? 0 : 1023 - 15;
        mesh_burst(lo, lo + 15);
      end
      drain();
    end

    $display("sent %0d words: %0d loads, %0d triangles (%0d degenerate), %0d reads",
             sent, loads, tris, zero_det, reads);
    $display("checked %0d tangent results", sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("vertex_tangent_generator_top_tb passed");
    else
      $display("vertex_tangent_generator_top_tb failed");
    $finish;
  end
endmodule
